### rtl/core/rcfd_pkg.sv
// Package with the shared types, constants and CRC function of the RC channels frame decoder.
`timescale 1ns / 1ps

package rcfd_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 64;
  localparam int unsigned CHANNEL_COUNT   = 16;
  localparam int unsigned PAYLOAD_BYTES   = 22;
  localparam int unsigned PAYLOAD_BITS    = 8 * PAYLOAD_BYTES;
  localparam int unsigned PAY_IDX_W       = $clog2(PAYLOAD_BYTES);
  localparam int unsigned CH_IDX_W        = $clog2(CHANNEL_COUNT);
  localparam int unsigned VALUE_W         = 11;
  localparam int unsigned CFG_IDX_W       = 8;

  localparam logic [7:0] SYNC_RESET  = 8'hC8;
  localparam logic [7:0] TYPE_RESET  = 8'h16;
  localparam logic [7:0] CRC_POLY    = 8'hD5;
  localparam logic [VALUE_W-1:0] VALUE_MASK = 11'h7FF;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 8'd1;

  // Smallest length that covers the bytes of each 4-channel group.
  localparam logic [7:0] GROUP_NEED [4] = '{8'd8, 8'd13, 8'd19, 8'd24};

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_CRC  = 2'd1,
    ST_OTHER    = 2'd2,
    ST_BAD_SYNC = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic [3:0]         channel_index;
    logic [VALUE_W-1:0] channel_value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [7:0] length;
  } frame_evt_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/rc_channels_frame_decoder_unit.sv
// Top level of the RC channels frame decoder: configuration, channel store and result sequencer.
// A frame-end word raises a registered frame event, which starts the result burst.
// Throughput: one byte word per cycle inside a frame; after a frame end the input stalls while
// the event is pending and until the burst (1 word, or CHANNEL_COUNT words if good) is loaded.
// Reset clears the frame state, the channel values and the output valid flag, and loads
// the configuration defaults; the payload bytes and the output word are not reset.
`timescale 1ns / 1ps

module rc_channels_frame_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rcfd_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rcfd_pkg::out_word_t                out_word_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                         cfg_data_i
);

  logic [7:0] sync_value_q, frame_type_q;
  logic       in_acc, out_acc;

  rcfd_pkg::frame_evt_t             evt;
  logic [rcfd_pkg::PAYLOAD_BITS-1:0] payload;

  logic [rcfd_pkg::VALUE_W-1:0] chan_q [rcfd_pkg::CHANNEL_COUNT];
  logic [rcfd_pkg::VALUE_W-1:0] chan_d [rcfd_pkg::CHANNEL_COUNT];

  logic                          emit_active_q, emit_active_d;
  logic [rcfd_pkg::CH_IDX_W-1:0] emit_cnt_q, emit_cnt_d;
  rcfd_pkg::status_e             emit_status_q, emit_status_d;
  logic                          out_valid_q, out_valid_d;
  rcfd_pkg::out_word_t           out_word_q, out_word_d;
  logic                          load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = evt.valid | emit_active_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q <= rcfd_pkg::SYNC_RESET;
      frame_type_q <= rcfd_pkg::TYPE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rcfd_pkg::CFG_SYNC_VALUE: sync_value_q <= cfg_data_i;
        rcfd_pkg::CFG_FRAME_TYPE: frame_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rcfd_frame_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_acc_i     (in_acc),
    .in_word_i    (in_word_i),
    .sync_value_i (sync_value_q),
    .frame_type_i (frame_type_q),
    .evt_o        (evt),
    .payload_o    (payload)
  );

  always_comb begin
    for (int k = 0; k < rcfd_pkg::CHANNEL_COUNT; k++) begin
      chan_d[k] = chan_q[k];
      if (evt.valid && evt.status == rcfd_pkg::ST_GOOD &&
          evt.length >= rcfd_pkg::GROUP_NEED[k / 4]) begin
        chan_d[k] = payload[rcfd_pkg::VALUE_W*k +: rcfd_pkg::VALUE_W] & rcfd_pkg::VALUE_MASK;
      end
    end
  end

  always_comb begin
    emit_active_d = emit_active_q;
    emit_cnt_d    = emit_cnt_q;
    emit_status_d = emit_status_q;
    out_valid_d   = out_valid_q;
    out_word_d    = out_word_q;
    load          = emit_active_q & (~out_valid_q | ~out_stall_i);
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (emit_status_q == rcfd_pkg::ST_GOOD) begin
        out_word_d.frame_status  = emit_status_q;
        out_word_d.channel_index = 4'(emit_cnt_q);
        out_word_d.channel_value = chan_q[emit_cnt_q];
        out_word_d.last = (emit_cnt_q == rcfd_pkg::CH_IDX_W'(rcfd_pkg::CHANNEL_COUNT - 1));
      end else begin
        out_word_d.frame_status  = emit_status_q;
        out_word_d.channel_index = '0;
        out_word_d.channel_value = '0;
        out_word_d.last          = 1'b1;
      end
      emit_cnt_d = emit_cnt_q + 1'b1;
      if (out_word_d.last) begin
        emit_active_d = 1'b0;
      end
    end
    if (evt.valid) begin
      emit_active_d = 1'b1;
      emit_cnt_d    = '0;
      emit_status_d = evt.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_active_q <= 1'b0;
      emit_cnt_q    <= '0;
      emit_status_q <= rcfd_pkg::ST_GOOD;
      out_valid_q   <= 1'b0;
      for (int k = 0; k < rcfd_pkg::CHANNEL_COUNT; k++) begin
        chan_q[k] <= '0;
      end
    end else begin
      emit_active_q <= emit_active_d;
      emit_cnt_q    <= emit_cnt_d;
      emit_status_q <= emit_status_d;
      out_valid_q   <= out_valid_d;
      chan_q        <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_end_starts_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.frame_end |=> evt.valid)
    else $error("frame end word did not raise a frame event");

  a_status_word_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_status != rcfd_pkg::ST_GOOD |->
      out_word_o.last && out_word_o.channel_index == 4'd0 && out_word_o.channel_value == '0)
    else $error("status word carries channel data or is not last");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_word_o.last |=>
      out_valid_o && out_word_o.channel_index == 4'($past(out_word_o.channel_index) + 4'd1))
    else $error("channel burst broke off or skipped an index");

endmodule

### rtl/core/rcfd_frame_parser.sv
// Byte-level frame parser: header checks, CRC, payload capture and end-of-frame status.
`timescale 1ns / 1ps

module rcfd_frame_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_acc_i,
  input  rcfd_pkg::in_word_t                in_word_i,
  input  logic [7:0]                        sync_value_i,
  input  logic [7:0]                        frame_type_i,
  output rcfd_pkg::frame_evt_t              evt_o,
  output logic [rcfd_pkg::PAYLOAD_BITS-1:0] payload_o
);

  logic [6:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic       sync_ok_q, sync_ok_d;
  logic       type_ok_q, type_ok_d;
  logic [7:0] crc_q, crc_d;
  logic       crc_ok_q, crc_ok_d;
  rcfd_pkg::frame_evt_t evt_q, evt_d;

  logic [7:0] payload_q [rcfd_pkg::PAYLOAD_BYTES];
  logic                          pay_we;
  logic [rcfd_pkg::PAY_IDX_W-1:0] pay_idx;

  logic [7:0] b;
  assign b = in_word_i.rx_byte;

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    sync_ok_d = sync_ok_q;
    type_ok_d = type_ok_q;
    crc_d     = crc_q;
    crc_ok_d  = crc_ok_q;
    evt_d     = '0;
    pay_we    = 1'b0;
    pay_idx   = rcfd_pkg::PAY_IDX_W'(pos_q - 7'd3);
    if (in_acc_i) begin
      if (pos_q < 7'(rcfd_pkg::MAX_FRAME_BYTES)) begin
        if (pos_q == 7'd0) begin
          sync_ok_d = (b == sync_value_i);
        end else if (pos_q == 7'd1) begin
          len_d = b;
          crc_d = '0;
        end else begin
          if (pos_q == 7'd2) begin
            type_ok_d = (b == frame_type_i);
          end
          if (len_q >= 8'd2 && {1'b0, pos_q} <= len_q) begin
            crc_d = rcfd_pkg::crc_update(crc_q, b);
          end
          if (len_q >= 8'd2 && {2'b00, pos_q} == ({1'b0, len_q} + 9'd1)) begin
            crc_ok_d = (b == crc_q);
          end
          if (pos_q >= 7'd3 && pos_q < 7'(3 + rcfd_pkg::PAYLOAD_BYTES)) begin
            pay_we = 1'b1;
          end
        end
        pos_d = pos_q + 7'd1;
      end
      if (in_word_i.frame_end) begin
        evt_d.valid  = 1'b1;
        evt_d.length = len_d;
        if (!sync_ok_d) begin
          evt_d.status = rcfd_pkg::ST_BAD_SYNC;
        end else if (pos_d < 7'd3) begin
          evt_d.status = rcfd_pkg::ST_BAD_CRC;
        end else if (!type_ok_d) begin
          evt_d.status = rcfd_pkg::ST_OTHER;
        end else if (!crc_ok_d) begin
          evt_d.status = rcfd_pkg::ST_BAD_CRC;
        end else begin
          evt_d.status = rcfd_pkg::ST_GOOD;
        end
        pos_d     = '0;
        len_d     = '0;
        sync_ok_d = 1'b0;
        type_ok_d = 1'b0;
        crc_d     = '0;
        crc_ok_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      sync_ok_q <= 1'b0;
      type_ok_q <= 1'b0;
      crc_q     <= '0;
      crc_ok_q  <= 1'b0;
      evt_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      len_q     <= len_d;
      sync_ok_q <= sync_ok_d;
      type_ok_q <= type_ok_d;
      crc_q     <= crc_d;
      crc_ok_q  <= crc_ok_d;
      evt_q     <= evt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      payload_q[pay_idx] <= b;
    end
  end

  always_comb begin
    for (int i = 0; i < rcfd_pkg::PAYLOAD_BYTES; i++) begin
      payload_o[8*i +: 8] = payload_q[i];
    end
  end

  assign evt_o = evt_q;

endmodule

### tb/rc_channels_frame_decoder_unit_checker.sv
// Checker that predicts and compares the result words of the RC channels frame decoder.
`timescale 1ns / 1ps

module rc_channels_frame_decoder_unit_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  rcfd_pkg::in_word_t             in_word_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  rcfd_pkg::out_word_t            out_word_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  localparam logic [7:0]  SYNC_AT_RESET    = 8'd200;
  localparam logic [7:0]  TYPE_AT_RESET    = 8'd22;
  localparam int unsigned FRAME_BYTE_LIMIT = 64;
  localparam int unsigned STORED_BYTES     = 22;
  localparam int unsigned CHANNELS         = 16;
  localparam logic [7:0]  CRC8_POLY        = 8'hD5;
  localparam int unsigned GROUP_LEN [4]    = '{8, 13, 19, 24};

  logic [7:0]          sync_code;
  logic [7:0]          chan_type;
  int unsigned         byte_pos;
  int unsigned         len_field;
  logic                sync_seen;
  logic                type_seen;
  logic                crc_good;
  logic [7:0]          crc_run;
  logic [7:0]          payload_bytes [STORED_BYTES];
  logic [10:0]         chan_values [CHANNELS];
  rcfd_pkg::out_word_t awaited_words [$];
  rcfd_pkg::out_word_t oldest;

  function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [10:0] unpack_value(input int unsigned ch);
    int unsigned first_bit;
    logic [23:0] window;
    first_bit = 11 * ch;
    window    = '0;
    for (int j = 0; j < 3; j++) begin
      if (first_bit / 8 + j < STORED_BYTES) begin
        window[8*j +: 8] = payload_bytes[first_bit / 8 + j];
      end
    end
    return 11'(window >> (first_bit % 8));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
    fail_count_o++;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic at_end);
    rcfd_pkg::status_e   verdict;
    rcfd_pkg::out_word_t w;
    if (byte_pos < FRAME_BYTE_LIMIT) begin
      if (byte_pos == 0) begin
        sync_seen = (b == sync_code);
      end else if (byte_pos == 1) begin
        len_field = b;
        crc_run   = '0;
      end else begin
        if (byte_pos == 2) begin
          type_seen = (b == chan_type);
        end
        if (len_field >= 2 && byte_pos <= len_field) begin
          crc_run = crc_after(crc_run, b);
        end
        if (len_field >= 2 && byte_pos == len_field + 1) begin
          crc_good = (b == crc_run);
        end
        if (byte_pos >= 3 && byte_pos - 3 < STORED_BYTES) begin
          payload_bytes[byte_pos - 3] = b;
        end
      end
      byte_pos++;
    end
    if (at_end) begin
      if (!sync_seen) begin
        verdict = rcfd_pkg::ST_BAD_SYNC;
      end else if (byte_pos < 3) begin
        verdict = rcfd_pkg::ST_BAD_CRC;
      end else if (!type_seen) begin
        verdict = rcfd_pkg::ST_OTHER;
      end else if (!crc_good) begin
        verdict = rcfd_pkg::ST_BAD_CRC;
      end else begin
        verdict = rcfd_pkg::ST_GOOD;
      end
      if (verdict != rcfd_pkg::ST_GOOD) begin
        w.frame_status  = verdict;
        w.channel_index = '0;
        w.channel_value = '0;
        w.last          = 1'b1;
        awaited_words.push_back(w);
      end else begin
        for (int k = 0; k < CHANNELS; k++) begin
          if (len_field >= GROUP_LEN[k / 4]) begin
            chan_values[k] = unpack_value(k);
          end
        end
        for (int k = 0; k < CHANNELS; k++) begin
          w.frame_status  = rcfd_pkg::ST_GOOD;
          w.channel_index = 4'(k);
          w.channel_value = chan_values[k];
          w.last          = (k == CHANNELS - 1);
          awaited_words.push_back(w);
        end
      end
      byte_pos  = 0;
      len_field = 0;
      sync_seen = 1'b0;
      type_seen = 1'b0;
      crc_run   = '0;
      crc_good  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_code    = SYNC_AT_RESET;
      chan_type    = TYPE_AT_RESET;
      byte_pos     = 0;
      len_field    = 0;
      sync_seen    = 1'b0;
      type_seen    = 1'b0;
      crc_run      = '0;
      crc_good     = 1'b0;
      fail_count_o = 0;
      for (int k = 0; k < CHANNELS; k++) begin
        chan_values[k] = '0;
      end
      awaited_words.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == rcfd_pkg::CFG_SYNC_VALUE) begin
          sync_code = cfg_data_i;
        end else if (cfg_index_i == rcfd_pkg::CFG_FRAME_TYPE) begin
          chan_type = cfg_data_i;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("result word with none awaited", out_word_i, '0);
        end else begin
          oldest = awaited_words.pop_front();
          if (out_word_i.frame_status !== oldest.frame_status) begin
            report_mismatch("frame_status", out_word_i.frame_status, oldest.frame_status);
          end
          if (out_word_i.channel_index !== oldest.channel_index) begin
            report_mismatch("channel_index", out_word_i.channel_index, oldest.channel_index);
          end
          if (out_word_i.channel_value !== oldest.channel_value) begin
            report_mismatch("channel_value", out_word_i.channel_value, oldest.channel_value);
          end
          if (out_word_i.last !== oldest.last) begin
            report_mismatch("last", out_word_i.last, oldest.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_byte(in_word_i.rx_byte, in_word_i.frame_end);
      end
      pending_o <= awaited_words.size();
    end
  end

endmodule

### tb/rc_channels_frame_decoder_unit_test.sv
// Top of the RC channels frame decoder testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module rc_channels_frame_decoder_unit_test;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_BYTES   = 40;
  localparam int PHASES        = 6;

  typedef enum int {
    FK_GOOD,
    FK_OTHER_TYPE,
    FK_BAD_CRC,
    FK_SHORT,
    FK_BAD_SYNC,
    FK_TINY,
    FK_NO_TYPE,
    FK_LONG_LEN,
    FK_OVERLONG,
    FK_NOISE
  } frame_kind_e;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  rcfd_pkg::in_word_t             in_word   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  rcfd_pkg::out_word_t            out_word;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data  = '0;
  logic                           hold_req  = 1'b0;
  int                             fail_count;
  int                             pending;
  int                             idle_pct  = 0;
  int                             stall_pct = 0;
  int                             bytes_sent = 0;
  int                             quiet_cycles = 0;
  logic [7:0]                     cur_sync = rcfd_pkg::SYNC_RESET;
  logic [7:0]                     cur_type = rcfd_pkg::TYPE_RESET;
  logic [7:0]                     frame_q [$];

  always #10 clk = ~clk;

  rc_channels_frame_decoder_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rc_channels_frame_decoder_unit_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'hD5) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic int random_length();
    return ($urandom_range(99, 0) < 75) ? $urandom_range(26, 2) : $urandom_range(62, 27);
  endfunction

  task automatic build_channels_frame(input int len, input logic [7:0] type_code);
    logic [7:0] crc;
    logic [7:0] b;
    frame_q.delete();
    frame_q.push_back(cur_sync);
    frame_q.push_back(8'(len));
    frame_q.push_back(type_code);
    crc = crc8_next(8'h00, type_code);
    for (int i = 3; i <= len; i++) begin
      b = 8'($urandom);
      frame_q.push_back(b);
      crc = crc8_next(crc, b);
    end
    frame_q.push_back(crc);
  endtask

  task automatic build_frame(input frame_kind_e kind);
    int len;
    int keep;
    case (kind)
      FK_GOOD: begin
        build_channels_frame(random_length(), cur_type);
        if ($urandom_range(99, 0) < 15) begin
          repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom));
        end
      end
      FK_OTHER_TYPE: begin
        build_channels_frame(random_length(), cur_type ^ 8'($urandom_range(255, 1)));
      end
      FK_BAD_CRC: begin
        build_channels_frame(random_length(), cur_type);
        frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'($urandom_range(255, 1));
      end
      FK_SHORT: begin
        len = random_length();
        build_channels_frame(len, cur_type);
        keep = $urandom_range(len + 1, 3);
        while (frame_q.size() > keep) frame_q.pop_back();
      end
      FK_BAD_SYNC: begin
        frame_q.delete();
        frame_q.push_back(cur_sync ^ 8'($urandom_range(255, 1)));
        repeat ($urandom_range(9, 0)) frame_q.push_back(8'($urandom));
      end
      FK_TINY: begin
        frame_q = {cur_sync, 8'($urandom_range(1, 0)), cur_type};
        repeat ($urandom_range(3, 0)) frame_q.push_back(8'($urandom));
      end
      FK_NO_TYPE: begin
        frame_q = {cur_sync};
        if ($urandom_range(1, 0) == 1) frame_q.push_back(8'($urandom));
      end
      FK_LONG_LEN: begin
        frame_q = {cur_sync, 8'($urandom_range(255, 62)), cur_type};
        repeat ($urandom_range(66, 0)) frame_q.push_back(8'($urandom));
      end
      FK_OVERLONG: begin
        build_channels_frame(random_length(), cur_type);
        keep = $urandom_range(72, 65);
        while (frame_q.size() < keep) frame_q.push_back(8'($urandom));
      end
      default: begin
        frame_q.delete();
        repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom));
      end
    endcase
  endtask

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(99, 0);
    if (r < 45) return FK_GOOD;
    if (r < 55) return FK_OTHER_TYPE;
    if (r < 63) return FK_BAD_CRC;
    if (r < 71) return FK_SHORT;
    if (r < 77) return FK_BAD_SYNC;
    if (r < 81) return FK_TINY;
    if (r < 84) return FK_NO_TYPE;
    if (r < 89) return FK_LONG_LEN;
    if (r < 91) return FK_OVERLONG;
    return FK_NOISE;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic at_end);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{rx_byte: b, frame_end: at_end};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      send_word(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] sync_code, input logic [7:0] type_code);
    cfg_valid <= 1'b1;
    cfg_index <= rcfd_pkg::CFG_SYNC_VALUE;
    cfg_data  <= sync_code;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= rcfd_pkg::CFG_FRAME_TYPE;
    cfg_data  <= type_code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_sync = sync_code;
    cur_type = type_code;
  endtask

  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int phase_start;
    bit first_random;
    first_random = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Header and status corner cases at the reset configuration.
    frame_q = {cur_sync ^ 8'hFF};
    send_frame();
    frame_q = {8'h00, 8'hFF};
    send_frame();
    frame_q = {cur_sync};
    send_frame();
    frame_q = {cur_sync, 8'h00, cur_type, 8'h00};
    send_frame();
    frame_q = {cur_sync, 8'h01, cur_type, 8'hFF};
    send_frame();
    build_channels_frame(2, cur_type ^ 8'h80);
    send_frame();
    build_channels_frame(2, cur_type);
    frame_q[3] = frame_q[3] ^ 8'h01;
    send_frame();
    build_channels_frame(2, cur_type);
    frame_q.pop_back();
    send_frame();
    build_channels_frame(2, cur_type);
    send_frame();
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       write_regs(rcfd_pkg::SYNC_RESET, rcfd_pkg::TYPE_RESET);
        1:       write_regs(8'h00, 8'h00);
        2:       write_regs(8'hFF, 8'hFF);
        5:       write_regs(rcfd_pkg::SYNC_RESET, rcfd_pkg::TYPE_RESET);
        default: write_regs(8'($urandom), 8'($urandom));
      endcase
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 59; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (ph == 0) begin
        hold_req <= 1'b1;
      end
      phase_start = bytes_sent;
      while (bytes_sent < phase_start + PHASE_BYTES) begin
        // A full-length frame first, so that every stored payload byte is written.
        if (first_random) begin
          build_channels_frame(24, cur_type);
          first_random = 1'b0;
        end else begin
          build_frame(pick_kind());
        end
        send_frame();
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
